[src/ctnl_pkg.sv]
// Package for the calibration table lookup core.
// Holds command and status codes, field types and the entry and result structs.
// No dependencies.
package ctnl_pkg;

    // Command codes carried by the command word.
    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_CLEAR  = 3'd1;
    localparam logic [2:0] CMD_RENUM  = 3'd2;
    localparam logic [2:0] CMD_FIND   = 3'd3;
    localparam logic [2:0] CMD_NEAR   = 3'd4;
    localparam logic [2:0] CMD_MAX    = 3'd5;

    // Status codes carried by the response word.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic [2:0]  t_cmd;
    typedef logic [1:0]  t_status;
    typedef logic [15:0] t_u16;
    typedef logic [30:0] t_freq;
    typedef logic [5:0]  t_index;
    typedef logic [6:0]  t_count;

    // Entry fields other than the id, stored together in one memory.
    typedef struct packed {
        t_u16  divisor;
        t_u16  delay;
        t_freq frequency;
        t_u16  valid;
        t_u16  eye;
    } t_rest;

    // One response word.
    typedef struct packed {
        t_status status;
        t_index  found_index;
        t_u16    id;
        t_rest   rest;
        t_count  entry_count;
    } t_result;

    // Controls of the shared scan compare unit.
    typedef struct packed {
        logic  nearest;
        logic  first;
        t_u16  key_id;
        t_freq key_freq;
        t_freq best_metric;
    } t_scan_ctl;

    // Outputs of the shared scan compare unit.
    typedef struct packed {
        logic  match;
        logic  better;
        t_freq metric;
    } t_scan_res;

endpackage

[src/ctnl_if.sv]
// Handshake interfaces for the command and response channels.
// Depends on ctnl_pkg.
interface ctnl_cmd_if;
    import ctnl_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  command;
    t_u16  item_id;
    t_u16  item_divisor;
    t_u16  item_delay;
    t_freq item_frequency;
    t_u16  item_valid;
    t_u16  item_eye;

    modport source (
        output valid, command, item_id, item_divisor, item_delay,
               item_frequency, item_valid, item_eye,
        input  ready
    );
    modport sink (
        input  valid, command, item_id, item_divisor, item_delay,
               item_frequency, item_valid, item_eye,
        output ready
    );
endinterface

interface ctnl_rsp_if;
    import ctnl_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_index  found_index;
    t_u16    out_id;
    t_u16    out_divisor;
    t_u16    out_delay;
    t_freq   out_frequency;
    t_u16    out_valid;
    t_u16    out_eye;
    t_count  entry_count;

    modport source (
        output valid, status, found_index, out_id, out_divisor, out_delay,
               out_frequency, out_valid, out_eye, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_index, out_id, out_divisor, out_delay,
               out_frequency, out_valid, out_eye, entry_count,
        output ready
    );
endinterface

[src/ctnl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ctnl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ctnl_scan_unit.sv]
// Shared compare unit used once per scanned entry.
// Checks the id match and whether the entry beats the best so far.
// Depends on ctnl_pkg.
module ctnl_scan_unit (
    input  ctnl_pkg::t_scan_ctl i_ctl,
    input  ctnl_pkg::t_u16      i_data_id,
    input  ctnl_pkg::t_freq     i_data_freq,
    output ctnl_pkg::t_scan_res o_res
);
    import ctnl_pkg::*;

    t_freq w_dist;

    // Absolute distance between the requested and the stored frequency.
    assign w_dist = (i_ctl.key_freq >= i_data_freq) ? (i_ctl.key_freq - i_data_freq)
                                                    : (i_data_freq - i_ctl.key_freq);

    // Nearest search keeps the earliest smallest distance; max search keeps
    // the earliest strictly greatest frequency above the running maximum.
    always_comb begin
        o_res.match = (i_data_id == i_ctl.key_id);
        if (i_ctl.nearest) begin
            o_res.metric = w_dist;
            o_res.better = i_ctl.first || (w_dist < i_ctl.best_metric);
        end else begin
            o_res.metric = i_data_freq;
            o_res.better = (i_data_freq > i_ctl.best_metric);
        end
    end

endmodule

[src/calibration_table_nearest_lookup_core.sv]
// Calibration table with id, nearest frequency and max frequency lookups.
// Append, clear, unused codes and any command on an empty table go straight from acceptance
// to the response stage; renumber first rewrites every id, lookups first read every entry
// with one memory read a cycle, then fetch and emit the winner. The next command is taken
// once its response is loaded into the response register, later while a response word waits unaccepted.
// Synchronous active-low reset empties the table; entry memories are not cleared.
module calibration_table_nearest_lookup_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctnl_cmd_if.sink    i_cmd,
    ctnl_rsp_if.source  o_rsp
);
    import ctnl_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_RENUM, S_FETCH, S_EMIT, S_DONE
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [IW-1:0]   r_addr;
    logic            r_issue;
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    logic [IW-1:0]   r_best;
    t_freq           r_metric;
    logic            r_first;
    logic            r_found;
    t_cmd            r_cmd;
    t_u16            r_key_id;
    t_freq           r_key_freq;
    t_result         r_res;
    t_result         r_out;
    logic            r_out_valid;

    t_result         n_res;
    t_result         n_out;

    logic            w_accept;
    logic            w_full;
    logic [CW-1:0]   w_last;
    logic            w_append;
    logic            w_out_load;
    logic            w_id_we;
    logic [IW-1:0]   w_id_waddr;
    t_u16            w_id_wdata;
    t_rest           w_rest_wdata;
    logic [IW-1:0]   w_raddr;
    t_u16            w_rd_id;
    t_rest           w_rd_rest;
    t_scan_ctl       w_scan_ctl;
    t_scan_res       w_scan_res;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CW'(TABLE_DEPTH));
    assign w_last      = r_count - CW'(1);
    assign w_append    = w_accept && (i_cmd.command == CMD_APPEND) && !w_full;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // Memory write and read address selection.
    assign w_id_we      = w_append || (r_state == S_RENUM);
    assign w_id_waddr   = (r_state == S_RENUM) ? r_addr : r_count[IW-1:0];
    assign w_id_wdata   = (r_state == S_RENUM) ? 16'(w_last - CW'(r_addr)) : i_cmd.item_id;
    assign w_rest_wdata = '{divisor:   i_cmd.item_divisor,
                            delay:     i_cmd.item_delay,
                            frequency: i_cmd.item_frequency,
                            valid:     i_cmd.item_valid,
                            eye:       i_cmd.item_eye};
    assign w_raddr      = (r_state == S_SCAN) ? r_addr : r_best;

    ctnl_ram #(.WIDTH($bits(t_u16)), .DEPTH(TABLE_DEPTH)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_id_we),
        .i_waddr (w_id_waddr),
        .i_wdata (w_id_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_id)
    );

    ctnl_ram #(.WIDTH($bits(t_rest)), .DEPTH(TABLE_DEPTH)) u_rest_ram (
        .i_clk   (i_clk),
        .i_we    (w_append),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (w_rest_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_rest)
    );

    // Shared compare unit, fed by the entry read in the previous cycle.
    assign w_scan_ctl = '{nearest:     (r_cmd == CMD_NEAR),
                          first:       r_first,
                          key_id:      r_key_id,
                          key_freq:    r_key_freq,
                          best_metric: r_metric};

    ctnl_scan_unit u_scan (
        .i_ctl       (w_scan_ctl),
        .i_data_id   (w_rd_id),
        .i_data_freq (w_rd_rest.frequency),
        .o_res       (w_scan_res)
    );

    // Response word set up when a command word is accepted.
    always_comb begin
        n_res        = '0;
        n_res.status = ST_MISS;
        case (i_cmd.command)
            CMD_APPEND: begin
                if (w_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_res.status      = ST_OK;
                    n_res.found_index = 6'(r_count);
                    n_res.id          = i_cmd.item_id;
                    n_res.rest        = w_rest_wdata;
                end
            end
            CMD_CLEAR, CMD_RENUM: begin
                n_res.status = ST_OK;
            end
            default: begin
            end
        endcase
    end

    // Response word as queued, with the entry count after the command.
    always_comb begin
        n_out             = r_res;
        n_out.entry_count = 7'(r_count);
    end

    // Sequencer, table count and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_issue     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= (r_state == S_SCAN) && r_issue;
            r_out_valid <= w_out_load || (r_out_valid && !o_rsp.ready);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= i_cmd.command;
                        r_key_id   <= i_cmd.item_id;
                        r_key_freq <= i_cmd.item_frequency;
                        r_res      <= n_res;
                        r_addr     <= '0;
                        r_issue    <= 1'b1;
                        r_found    <= 1'b0;
                        r_first    <= 1'b1;
                        r_best     <= '0;
                        r_metric   <= '0;
                        case (i_cmd.command)
                            CMD_APPEND: begin
                                if (!w_full) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_DONE;
                            end
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            CMD_RENUM: begin
                                r_state <= (r_count == '0) ? S_DONE : S_RENUM;
                            end
                            CMD_FIND, CMD_NEAR, CMD_MAX: begin
                                r_state <= (r_count == '0) ? S_DONE : S_SCAN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RENUM: begin
                    // One id written per cycle, first entry gets the highest id.
                    if (CW'(r_addr) == w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                S_SCAN: begin
                    // Issue one read per cycle over the held entries.
                    if (r_issue) begin
                        r_rd_idx <= r_addr;
                        if (CW'(r_addr) == w_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + IW'(1);
                        end
                    end
                    // Judge the entry read in the previous cycle.
                    if (r_rd_vld) begin
                        if (r_cmd == CMD_FIND) begin
                            if (w_scan_res.match && !r_found) begin
                                r_found <= 1'b1;
                                r_best  <= r_rd_idx;
                            end
                        end else if (w_scan_res.better) begin
                            r_best   <= r_rd_idx;
                            r_metric <= w_scan_res.metric;
                            r_first  <= 1'b0;
                        end
                        if (CW'(r_rd_idx) == w_last) begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // The winning entry has been read back from both memories.
                    if ((r_cmd != CMD_FIND) || r_found) begin
                        r_res <= '{status:      ST_OK,
                                   found_index: 6'(r_best),
                                   id:          w_rd_id,
                                   rest:        w_rd_rest,
                                   entry_count: '0};
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Response channel driven straight from the response register.
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.found_index   = r_out.found_index;
    assign o_rsp.out_id        = r_out.id;
    assign o_rsp.out_divisor   = r_out.rest.divisor;
    assign o_rsp.out_delay     = r_out.rest.delay;
    assign o_rsp.out_frequency = r_out.rest.frequency;
    assign o_rsp.out_valid     = r_out.rest.valid;
    assign o_rsp.out_eye       = r_out.rest.eye;
    assign o_rsp.entry_count   = r_out.entry_count;

endmodule

[src/ctnl_checker.sv]
// Port-level assertions for the calibration table lookup core, and their bind.
// Depends on ctnl_pkg and calibration_table_nearest_lookup_core.
module ctnl_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cmd_valid,
    input logic                 i_cmd_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input ctnl_pkg::t_status    i_status,
    input ctnl_pkg::t_index     i_found_index,
    input ctnl_pkg::t_freq      i_out_frequency,
    input ctnl_pkg::t_count     i_entry_count
);
    import ctnl_pkg::*;

    // A stalled response word stays offered with the same status.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status))
        else $error("response word dropped or changed while stalled");

    // The core works on one command word at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command word taken while another is in work");

    // The reported count never exceeds the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (int'(i_entry_count) <= TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A full report only happens with the table at its depth.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_FULL) |-> (i_entry_count == 7'(TABLE_DEPTH)))
        else $error("full status with table not full");

    // A miss carries no entry.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_MISS) |-> (i_found_index == '0) &&
        (i_out_frequency == '0))
        else $error("miss status with entry data");

endmodule

bind calibration_table_nearest_lookup_core ctnl_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_ctnl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_found_index   (o_rsp.found_index),
    .i_out_frequency (o_rsp.out_frequency),
    .i_entry_count   (o_rsp.entry_count)
);

[bench/ctnl_table_checker.sv]
`timescale 1ns / 100ps
// Checker for the calibration table lookup core: watches the command and response
// channels, predicts each response word and compares it field by field.
// Depends on ctnl_pkg and the ctnl_cmd_if / ctnl_rsp_if interfaces.
module ctnl_table_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ctnl_cmd_if  i_cmd,
    ctnl_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import ctnl_pkg::*;

    // Shadow copy of the table held by the block.
    t_u16    shadow_ids  [TABLE_DEPTH];
    t_rest   shadow_rest [TABLE_DEPTH];
    int      shadow_fill = 0;

    // Response words predicted but not yet seen, oldest first.
    t_result expected_responses[$];
    int      mismatch_count = 0;
    int      backlog = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = backlog;

    // One line per mismatch, and the count grows by one.
    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] seen);
        mismatch_count++;
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, seen);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] seen);
        if (seen !== want) begin
            report_mismatch(what, want, seen);
        end
    endtask

    // Response word that returns held entry idx.
    function automatic t_result entry_response(int idx);
        t_result r;
        r             = '0;
        r.status      = ST_OK;
        r.found_index = t_index'(idx);
        r.id          = shadow_ids[idx];
        r.rest        = shadow_rest[idx];
        return r;
    endfunction

    // Applies one command word to the shadow table and returns its response word.
    function automatic t_result table_response(t_cmd cmd, t_u16 key_id, t_rest fields);
        t_result r;
        int      n;
        int      i;
        int      best;
        t_freq   best_gap;
        t_freq   gap;
        t_freq   top_freq;
        r        = '0;
        r.status = ST_MISS;
        n        = shadow_fill;
        case (cmd)
            CMD_APPEND: begin
                if (n >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_ids[n]  = key_id;
                    shadow_rest[n] = fields;
                    r = entry_response(n);
                    n++;
                end
            end
            CMD_CLEAR: begin
                n        = 0;
                r.status = ST_OK;
            end
            CMD_RENUM: begin
                for (i = 0; i < n; i++) begin
                    shadow_ids[i] = t_u16'(n - 1 - i);
                end
                r.status = ST_OK;
            end
            CMD_FIND: begin
                best = -1;
                for (i = 0; i < n; i++) begin
                    if (best < 0 && shadow_ids[i] == key_id) begin
                        best = i;
                    end
                end
                if (best >= 0) begin
                    r = entry_response(best);
                end
            end
            CMD_NEAR: begin
                // Strictly smaller distance wins, so the earliest entry keeps a tie.
                if (n > 0) begin
                    best     = 0;
                    best_gap = (fields.frequency > shadow_rest[0].frequency) ?
                               fields.frequency - shadow_rest[0].frequency :
                               shadow_rest[0].frequency - fields.frequency;
                    for (i = 1; i < n; i++) begin
                        gap = (fields.frequency > shadow_rest[i].frequency) ?
                              fields.frequency - shadow_rest[i].frequency :
                              shadow_rest[i].frequency - fields.frequency;
                        if (gap < best_gap) begin
                            best_gap = gap;
                            best     = i;
                        end
                    end
                    r = entry_response(best);
                end
            end
            CMD_MAX: begin
                // Entry 0 is returned when no frequency is above zero.
                if (n > 0) begin
                    best     = 0;
                    top_freq = '0;
                    for (i = 0; i < n; i++) begin
                        if (shadow_rest[i].frequency > top_freq) begin
                            top_freq = shadow_rest[i].frequency;
                            best     = i;
                        end
                    end
                    r = entry_response(best);
                end
            end
            default: begin
            end
        endcase
        shadow_fill   = n;
        r.entry_count = t_count'(n);
        return r;
    endfunction

    // Responses are handled before commands: a response accepted on the same edge
    // as a new command belongs to the earlier one.
    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        t_rest   fields;
        if (!i_rst_n) begin
            expected_responses.delete();
            shadow_fill = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                seen.status         = i_rsp.status;
                seen.found_index    = i_rsp.found_index;
                seen.id             = i_rsp.out_id;
                seen.rest.divisor   = i_rsp.out_divisor;
                seen.rest.delay     = i_rsp.out_delay;
                seen.rest.frequency = i_rsp.out_frequency;
                seen.rest.valid     = i_rsp.out_valid;
                seen.rest.eye       = i_rsp.out_eye;
                seen.entry_count    = i_rsp.entry_count;
                if (expected_responses.size() == 0) begin
                    report_mismatch("response word with no command waiting", 0,
                                    32'(seen.status));
                end else begin
                    want = expected_responses.pop_front();
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("found_index", 32'(want.found_index), 32'(seen.found_index));
                    check_field("out_id", 32'(want.id), 32'(seen.id));
                    check_field("out_divisor", 32'(want.rest.divisor),
                                32'(seen.rest.divisor));
                    check_field("out_delay", 32'(want.rest.delay), 32'(seen.rest.delay));
                    check_field("out_frequency", 32'(want.rest.frequency),
                                32'(seen.rest.frequency));
                    check_field("out_valid", 32'(want.rest.valid), 32'(seen.rest.valid));
                    check_field("out_eye", 32'(want.rest.eye), 32'(seen.rest.eye));
                    check_field("entry_count", 32'(want.entry_count), 32'(seen.entry_count));
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                fields.divisor   = i_cmd.item_divisor;
                fields.delay     = i_cmd.item_delay;
                fields.frequency = i_cmd.item_frequency;
                fields.valid     = i_cmd.item_valid;
                fields.eye       = i_cmd.item_eye;
                want = table_response(i_cmd.command, i_cmd.item_id, fields);
                expected_responses = {expected_responses, want};
            end
        end
        backlog = expected_responses.size();
    end

endmodule

[bench/tb_calibration_table_nearest_lookup_core.sv]
`timescale 1ns / 100ps
// Top of the calibration table lookup regression: clock, reset, command stimulus,
// response back-pressure and the verdict. Depends on ctnl_pkg, the channel
// interfaces, ctnl_table_checker and calibration_table_nearest_lookup_core.
module tb_calibration_table_nearest_lookup_core;
    import ctnl_pkg::*;

    localparam int         TABLE_DEPTH  = 64;
    localparam int         RANDOM_WORDS = 1100;
    localparam int         DRAIN_CYCLES = 100;
    // Command codes the block does not use.
    localparam logic [2:0] CMD_SPARE_A  = 3'd6;
    localparam logic [2:0] CMD_SPARE_B  = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   words_sent = 0;

    ctnl_cmd_if cmd_bus ();
    ctnl_rsp_if rsp_bus ();

    calibration_table_nearest_lookup_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    ctnl_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #8_000_000;
        $display("calibration_table_nearest_lookup_core regression: fail");
        $finish;
    end

    // Offers one command word, with random gaps before it outside a steady stretch, and waits for acceptance.
    task automatic send_word(t_cmd cmd, t_u16 id, t_rest fields);
        bit steady;
        steady = (words_sent >= 300 && words_sent < 520);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 24) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.command        <= cmd;
        cmd_bus.item_id        <= id;
        cmd_bus.item_divisor   <= fields.divisor;
        cmd_bus.item_delay     <= fields.delay;
        cmd_bus.item_frequency <= fields.frequency;
        cmd_bus.item_valid     <= fields.valid;
        cmd_bus.item_eye       <= fields.eye;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        words_sent++;
    endtask

    function automatic t_rest make_rest(t_u16 dv, t_u16 dl, t_freq fr, t_u16 vl, t_u16 ey);
        t_rest r;
        r.divisor   = dv;
        r.delay     = dl;
        r.frequency = fr;
        r.valid     = vl;
        r.eye       = ey;
        return r;
    endfunction

    // Small ids make finds hit, especially after a renumber.
    function automatic t_u16 random_id();
        return $urandom_range(0, 1) ? t_u16'($urandom_range(0, 15)) : t_u16'($urandom);
    endfunction

    // Frequency shapes: 0 full range, 1 small values with ties, 2 zero,
    // 3 near the top of the range, 4 a random pick of the others per word.
    function automatic t_rest random_rest(int fmode);
        int    shape;
        t_freq fr;
        shape = (fmode == 4) ? $urandom_range(0, 3) : fmode;
        case (shape)
            0:       fr = t_freq'($urandom);
            1:       fr = t_freq'($urandom_range(0, 15));
            2:       fr = '0;
            default: fr = 31'h7FFF_FFFF - t_freq'($urandom_range(0, 15));
        endcase
        return make_rest(t_u16'($urandom), t_u16'($urandom), fr, t_u16'($urandom),
                         t_u16'($urandom));
    endfunction

    // One well-formed sequence: an optional clear, a run of appends, then a mix of
    // lookups with an occasional renumber, append, clear or unused code.
    task automatic run_episode(bit overfill);
        int    fill_goal;
        int    probes;
        int    fmode;
        int    roll;
        t_u16  key;
        t_rest fields;
        fmode = $urandom_range(0, 4);
        if ($urandom_range(0, 99) < 70) begin
            send_word(CMD_CLEAR, t_u16'($urandom), random_rest(fmode));
        end
        roll = $urandom_range(0, 99);
        if (overfill || roll >= 94) begin
            fill_goal = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 6);
        end else if (roll >= 70) begin
            fill_goal = $urandom_range(9, 40);
        end else begin
            fill_goal = $urandom_range(0, 8);
        end
        repeat (fill_goal) send_word(CMD_APPEND, random_id(), random_rest(fmode));
        probes = $urandom_range(3, 15);
        repeat (probes) begin
            roll   = $urandom_range(0, 99);
            key    = random_id();
            fields = random_rest(fmode);
            if (roll < 30) begin
                send_word(CMD_FIND, key, fields);
            end else if (roll < 60) begin
                send_word(CMD_NEAR, key, fields);
            end else if (roll < 80) begin
                send_word(CMD_MAX, key, fields);
            end else if (roll < 88) begin
                send_word(CMD_RENUM, key, fields);
            end else if (roll < 94) begin
                send_word(CMD_APPEND, key, fields);
            end else if (roll < 97) begin
                send_word(CMD_CLEAR, key, fields);
            end else begin
                send_word((roll == 97) ? CMD_SPARE_A : CMD_SPARE_B, key, fields);
            end
        end
    endtask

    // Response side: random stalls, one long hold-off that backs the block up,
    // and a stretch with ready held high.
    initial begin
        int cycle_count;
        int hold_left;
        cycle_count   = 0;
        hold_left     = 0;
        rsp_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cycle_count++;
            if (cycle_count == 3000) begin
                hold_left = 400;
            end
            if (hold_left > 0) begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end else if (cycle_count >= 1000 && cycle_count < 2500) begin
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Command side: reset, directed words, random episodes, drain and verdict.
    initial begin
        int random_start;
        i_rst_n                = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.command        = CMD_APPEND;
        cmd_bus.item_id        = '0;
        cmd_bus.item_divisor   = '0;
        cmd_bus.item_delay     = '0;
        cmd_bus.item_frequency = '0;
        cmd_bus.item_valid     = '0;
        cmd_bus.item_eye       = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Lookups, unused codes and renumber on an empty table.
        send_word(CMD_FIND, 16'h0000, '0);
        send_word(CMD_NEAR, 16'h0000, make_rest('0, '0, 31'h7FFF_FFFF, '0, '0));
        send_word(CMD_MAX, 16'h0000, '0);
        send_word(CMD_SPARE_A, 16'hFFFF, '1);
        send_word(CMD_SPARE_B, 16'h0000, '0);
        send_word(CMD_RENUM, 16'h0000, '0);

        // Entries at the extremes of every field.
        send_word(CMD_APPEND, 16'hFFFF,
                  make_rest(16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_word(CMD_APPEND, 16'h0000, '0);
        send_word(CMD_APPEND, 16'h0005,
                  make_rest(16'h1234, 16'h00FF, 31'h0, 16'h8000, 16'h0001));
        send_word(CMD_MAX, 16'h0000, '0);
        send_word(CMD_FIND, 16'hFFFF, '0);
        send_word(CMD_FIND, 16'h1234, '0);
        // Entries 1 and 2 tie at zero distance; the earlier one wins.
        send_word(CMD_NEAR, 16'h0000, make_rest('0, '0, 31'h0, '0, '0));
        send_word(CMD_NEAR, 16'h0000, make_rest('0, '0, 31'h3FFF_FFFF, '0, '0));
        // After a renumber the ids run 2, 1, 0.
        send_word(CMD_RENUM, 16'h0000, '0);
        send_word(CMD_FIND, 16'h0000, '0);
        send_word(CMD_FIND, 16'h0002, '0);
        send_word(CMD_SPARE_B, 16'h0002, '0);

        // No frequency above zero: the max lookup falls back to entry 0.
        send_word(CMD_CLEAR, 16'h0000, '0);
        send_word(CMD_APPEND, 16'h0011, make_rest(16'h0001, 16'h0002, 31'h0, 16'h0003, 16'h0004));
        send_word(CMD_APPEND, 16'h0022, make_rest(16'h0005, 16'h0006, 31'h0, 16'h0007, 16'h0008));
        send_word(CMD_MAX, 16'h0000, '0);
        send_word(CMD_NEAR, 16'h0000, make_rest('0, '0, 31'h7FFF_FFFF, '0, '0));
        send_word(CMD_CLEAR, 16'h0000, '0);

        // Random part; the first episode always appends at least as many entries as the table holds.
        random_start = words_sent;
        run_episode(1'b1);
        while (words_sent - random_start < RANDOM_WORDS) run_episode(1'b0);

        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("calibration_table_nearest_lookup_core regression: pass");
        end else begin
            $display("calibration_table_nearest_lookup_core regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
src/ctnl_pkg.sv
src/ctnl_if.sv
src/ctnl_ram.sv
src/ctnl_scan_unit.sv
src/calibration_table_nearest_lookup_core.sv
src/ctnl_checker.sv
bench/ctnl_table_checker.sv
bench/tb_calibration_table_nearest_lookup_core.sv
